[rtl/core/overlap_tile_position_generator_unit_macros.svh]
// Assertion macros shared by the tile position generator RTL.
`ifndef OVERLAP_TILE_POSITION_GENERATOR_UNIT_MACROS_SVH
`define OVERLAP_TILE_POSITION_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OTPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tile position generator: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OTPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tile position generator: next-cycle check failed");

`endif

[rtl/core/otpg_pkg.sv]
// Package of types and constants for the tile position generator.
`timescale 1ns / 1ps

package otpg_pkg;

   localparam int REG_W      = 12;
   localparam int DIM_W      = 14;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_TILES  = 64;
   localparam int DIV_W      = DIM_W + 1;
   localparam int DIV_CNT_W  = 4;

   localparam logic [REG_W-1:0] TILE_SIZE_RESET   = 12'd192;
   localparam logic [REG_W-1:0] MIN_OVERLAP_RESET = 12'd12;

   localparam logic [CSR_IDX_W-1:0] REG_TILE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_OVERLAP = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV1,
      ST_COUNT,
      ST_DIV2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic emit_single;
      logic single_err;
      logic div1_start;
      logic div2_start;
      logic div_step;
      logic emit_tile;
   } cmd_type;

   typedef struct packed {
      logic fits;
      logic bad_overlap;
      logic too_many;
      logic div_done;
      logic tile_last;
      logic out_free;
   } status_type;

endpackage

[rtl/core/overlap_tile_position_generator_unit.sv]
// Usage of the overlapping tile position generator:
// The req channel carries one image dimension per item (req_valid, req_stall,
// req_dimension). For each item the rsp channel returns one item per tile:
// start position, tile index, a last flag on the final tile and an error flag.
// Tile size and minimum overlap are set through the csr write port (index 0
// and 1) while the block is idle; other indexes are ignored.
// When the dimension fits one tile, or the overlap is not below the tile size,
// the single item is loaded into the output register in the check state, once
// that register is free; a tile count above the limit gives its error item once the first division pass ends.
// Otherwise the tile count and the stride come from two passes of one
// restoring divider, one quotient bit per cycle; the first tile is loaded
// into the output register after the second pass and the others follow one
// per cycle while the receiver does not stall.
// Only one item is in work at a time: req_stall is high from acceptance until
// the final result of that item has been loaded into the output register.
// When the receiver stalls, the output register holds its item and the
// sequence waits. Reset clears the state machine and the output valid and
// loads tile size 192 and minimum overlap 12.
`timescale 1ns / 1ps
`include "overlap_tile_position_generator_unit_macros.svh"

module overlap_tile_position_generator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [otpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [otpg_pkg::REG_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [otpg_pkg::DIM_W-1:0]     req_dimension,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [otpg_pkg::DIM_W-1:0]     rsp_position,
   output logic [otpg_pkg::IDX_W-1:0]     rsp_tile_index,
   output logic                           rsp_last,
   output logic                           rsp_error
);

   otpg_pkg::cmd_type    cmd;
   otpg_pkg::status_type status;
   otpg_pkg::state_type  state;

   otpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   otpg_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_dimension  (req_dimension),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_position   (rsp_position),
      .rsp_tile_index (rsp_tile_index),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .cmd            (cmd),
      .status         (status)
   );

   // An error item always stands alone as tile zero at position zero.
   `OTPG_ASSERT_IMPL(a_error_single, clock, reset, rsp_valid && rsp_error, rsp_last && rsp_tile_index == '0 && rsp_position == '0)

   // While a tile sequence is still being delivered no new item is taken.
   `OTPG_ASSERT_IMPL(a_busy_mid_seq, clock, reset, rsp_valid && !rsp_last, req_stall && state == otpg_pkg::ST_EMIT)

   // Tiles of one item follow with consecutive indexes.
   `OTPG_ASSERT_NEXT(a_index_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last, !rsp_valid || rsp_tile_index == $past(rsp_tile_index) + 6'd1)

endmodule

[rtl/core/otpg_ctrl.sv]
// Controller state machine sequencing checks, divisions and tile emission.
`timescale 1ns / 1ps

module otpg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  otpg_pkg::status_type status,
   output otpg_pkg::cmd_type    cmd,
   output otpg_pkg::state_type  state
);

   otpg_pkg::state_type state_ff;
   otpg_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         otpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = otpg_pkg::ST_CHECK;
            end
         end
         otpg_pkg::ST_CHECK: begin
            if (status.fits || status.bad_overlap) begin
               if (status.out_free) begin
                  state_in = otpg_pkg::ST_IDLE;
               end
            end else begin
               state_in = otpg_pkg::ST_DIV1;
            end
         end
         otpg_pkg::ST_DIV1: begin
            if (status.div_done) begin
               state_in = otpg_pkg::ST_COUNT;
            end
         end
         otpg_pkg::ST_COUNT: begin
            if (status.too_many) begin
               if (status.out_free) begin
                  state_in = otpg_pkg::ST_IDLE;
               end
            end else begin
               state_in = otpg_pkg::ST_DIV2;
            end
         end
         otpg_pkg::ST_DIV2: begin
            if (status.div_done) begin
               state_in = otpg_pkg::ST_EMIT;
            end
         end
         otpg_pkg::ST_EMIT: begin
            if (status.out_free && status.tile_last) begin
               state_in = otpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = otpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         otpg_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         otpg_pkg::ST_CHECK: begin
            if (status.fits || status.bad_overlap) begin
               cmd.emit_single = status.out_free;
               cmd.single_err  = !status.fits;
            end else begin
               cmd.div1_start = 1'b1;
            end
         end
         otpg_pkg::ST_DIV1: begin
            cmd.div_step = !status.div_done;
         end
         otpg_pkg::ST_COUNT: begin
            if (status.too_many) begin
               cmd.emit_single = status.out_free;
               cmd.single_err  = 1'b1;
            end else begin
               cmd.div2_start = 1'b1;
            end
         end
         otpg_pkg::ST_DIV2: begin
            cmd.div_step = !status.div_done;
         end
         otpg_pkg::ST_EMIT: begin
            cmd.emit_tile = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

[rtl/core/otpg_dp.sv]
// Datapath: configuration registers, shared restoring divider, position
// accumulator and result register.
`timescale 1ns / 1ps

module otpg_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [otpg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [otpg_pkg::REG_W-1:0]           csr_wdata,
   input  logic [otpg_pkg::DIM_W-1:0]           req_dimension,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [otpg_pkg::DIM_W-1:0]           rsp_position,
   output logic [otpg_pkg::IDX_W-1:0]           rsp_tile_index,
   output logic                                 rsp_last,
   output logic                                 rsp_error,
   input  otpg_pkg::cmd_type                    cmd,
   output otpg_pkg::status_type                 status
);

   logic [otpg_pkg::REG_W-1:0]     tile_size_ff;
   logic [otpg_pkg::REG_W-1:0]     min_overlap_ff;
   logic [otpg_pkg::DIM_W-1:0]     dim_ff;
   logic [otpg_pkg::DIV_W-1:0]     num_ff;
   logic [otpg_pkg::REG_W-1:0]     rem_ff;
   logic [otpg_pkg::REG_W-1:0]     divisor_ff;
   logic [otpg_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [otpg_pkg::IDX_W-1:0]     count_m1_ff;
   logic [otpg_pkg::IDX_W-1:0]     idx_ff;
   logic [otpg_pkg::DIM_W-1:0]     acc_ff;
   logic                           rsp_valid_ff;
   logic [otpg_pkg::DIM_W-1:0]     rsp_position_ff;
   logic [otpg_pkg::IDX_W-1:0]     rsp_tile_index_ff;
   logic                           rsp_last_ff;
   logic                           rsp_error_ff;

   logic [otpg_pkg::DIM_W-1:0]     span;
   logic [otpg_pkg::REG_W-1:0]     eff;
   logic [otpg_pkg::DIV_W-1:0]     num1;
   logic [otpg_pkg::REG_W:0]       trial;
   logic [otpg_pkg::REG_W:0]       diff;
   logic                           q_bit;
   logic [otpg_pkg::DIM_W-1:0]     stride;
   logic                           tile_last;

   assign span = dim_ff - {{(otpg_pkg::DIM_W-otpg_pkg::REG_W){1'b0}}, tile_size_ff};
   assign eff  = tile_size_ff - min_overlap_ff;
   // Ceiling division is done as floor of (span + eff - 1) / eff.
   assign num1 = {1'b0, span} + {{(otpg_pkg::DIV_W-otpg_pkg::REG_W){1'b0}}, eff}
                 - otpg_pkg::DIV_W'(1);

   // One restoring division step: shift in the next numerator bit and
   // subtract the divisor when it fits.
   assign trial  = {rem_ff, num_ff[otpg_pkg::DIV_W-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign q_bit  = (trial >= {1'b0, divisor_ff});
   assign stride = num_ff[otpg_pkg::DIM_W-1:0];
   assign tile_last = (idx_ff == count_m1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff   <= otpg_pkg::TILE_SIZE_RESET;
         min_overlap_ff <= otpg_pkg::MIN_OVERLAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            otpg_pkg::REG_TILE_SIZE:   tile_size_ff   <= csr_wdata;
            otpg_pkg::REG_MIN_OVERLAP: min_overlap_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.emit_tile) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dim_ff <= req_dimension;
      end
      if (cmd.div1_start) begin
         num_ff     <= num1;
         rem_ff     <= '0;
         divisor_ff <= eff;
         div_cnt_ff <= '0;
      end else if (cmd.div2_start) begin
         num_ff      <= {1'b0, span};
         rem_ff      <= '0;
         divisor_ff  <= {{(otpg_pkg::REG_W-otpg_pkg::IDX_W){1'b0}},
                         num_ff[otpg_pkg::IDX_W-1:0]};
         div_cnt_ff  <= '0;
         count_m1_ff <= num_ff[otpg_pkg::IDX_W-1:0];
         idx_ff      <= '0;
         acc_ff      <= '0;
      end else if (cmd.div_step) begin
         num_ff     <= {num_ff[otpg_pkg::DIV_W-2:0], q_bit};
         rem_ff     <= q_bit ? diff[otpg_pkg::REG_W-1:0] : trial[otpg_pkg::REG_W-1:0];
         div_cnt_ff <= div_cnt_ff + otpg_pkg::DIV_CNT_W'(1);
      end else if (cmd.emit_tile) begin
         idx_ff <= idx_ff + otpg_pkg::IDX_W'(1);
         acc_ff <= acc_ff + stride;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         rsp_position_ff   <= '0;
         rsp_tile_index_ff <= '0;
         rsp_last_ff       <= 1'b1;
         rsp_error_ff      <= cmd.single_err;
      end else if (cmd.emit_tile) begin
         rsp_position_ff   <= tile_last ? span : acc_ff;
         rsp_tile_index_ff <= idx_ff;
         rsp_last_ff       <= tile_last;
         rsp_error_ff      <= 1'b0;
      end
   end

   always_comb begin
      status.fits        = (dim_ff <= {{(otpg_pkg::DIM_W-otpg_pkg::REG_W){1'b0}},
                                       tile_size_ff});
      status.bad_overlap = (min_overlap_ff >= tile_size_ff);
      status.too_many    = (num_ff > otpg_pkg::DIV_W'(otpg_pkg::MAX_TILES - 1));
      status.div_done    = (div_cnt_ff == otpg_pkg::DIV_CNT_W'(otpg_pkg::DIV_W));
      status.tile_last   = tile_last;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_tile_index = rsp_tile_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule
